// ----- sv/pfa_pkg.sv -----
// Shared types, constants and codes for the pool free-list allocator.
`default_nettype none

package pfa_pkg;

   // Pool geometry
   localparam int POOL_DEPTH = 256;
   localparam int SLOT_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int SIZE_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Entries the link memory really holds: slot indices are 8 bits wide
   localparam int LINK_DEPTH = (POOL_DEPTH < (1 << SLOT_W)) ? POOL_DEPTH : (1 << SLOT_W);
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SIZE      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALIGN     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ALIGNMENT = 2'd2;

   // Register reset values
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RST    = 9'd256;
   localparam logic [SIZE_W-1:0]  ELEMENT_SIZE_RST  = 16'd64;
   localparam logic [SIZE_W-1:0]  MAX_ALIGNMENT_RST = 16'd64;

   // Configuration as seen by the control logic
   typedef struct packed {
      logic [COUNT_W-1:0] slot_limit;
      logic [SIZE_W-1:0]  element_size;
      logic [SIZE_W-1:0]  max_alignment;
   } cfg_type;

   // Control sequencer states
   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_state_type;

endpackage

`default_nettype wire

// ----- sv/pfa_csr.sv -----
// Configuration registers and the derived slot limit.
`default_nettype none

module pfa_csr
   import pfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   logic [COUNT_W-1:0] slot_count_ff;
   logic [SIZE_W-1:0]  element_size_ff;
   logic [SIZE_W-1:0]  max_alignment_ff;
   logic               wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // Write the addressed register; drop writes to unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff    <= SLOT_COUNT_RST;
         element_size_ff  <= ELEMENT_SIZE_RST;
         max_alignment_ff <= MAX_ALIGNMENT_RST;
      end else if (wr_en) begin
         case (csr_index)
            CSR_SLOT_COUNT:    slot_count_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_ELEMENT_SIZE:  element_size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_MAX_ALIGNMENT: max_alignment_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the slot count at the link memory depth
   always_comb begin
      cfg.element_size  = element_size_ff;
      cfg.max_alignment = max_alignment_ff;
      if (slot_count_ff > COUNT_W'(LINK_DEPTH)) begin
         cfg.slot_limit = COUNT_W'(LINK_DEPTH);
      end else begin
         cfg.slot_limit = slot_count_ff;
      end
   end

endmodule

`default_nettype wire

// ----- sv/pfa_link_mem.sv -----
// Free-list link memory with per-entry valid bits for the ascending reset chain.
`default_nettype none

module pfa_link_mem
   import pfa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [LINK_AW-1:0] rd_addr,
   output logic      [SLOT_W-1:0]  rd_link,
   input  wire logic               wr_en,
   input  wire logic [LINK_AW-1:0] wr_addr,
   input  wire logic [SLOT_W-1:0]  wr_link
);

   logic [SLOT_W-1:0]     mem [LINK_DEPTH];
   logic [LINK_DEPTH-1:0] written_ff;
   logic [SLOT_W-1:0]     ram_q_ff;
   logic [SLOT_W-1:0]     dflt_q_ff;
   logic                  written_q_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_link;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         ram_q_ff     <= mem[rd_addr];
         dflt_q_ff    <= SLOT_W'(rd_addr) + SLOT_W'(1);
         written_q_ff <= written_ff[rd_addr];
      end
   end

   // Mark entries once written; reset restores the ascending chain
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // Unwritten entries read as their reset link
   assign rd_link = written_q_ff ? ram_q_ff : dflt_q_ff;

endmodule

`default_nettype wire

// ----- sv/pool_free_list_allocator.sv -----
// Top level: request sequencer, free-list head, live count and response register.
// A request is captured at accept, then executed once the response register can take the result.
// No new request is taken until the last has executed, as an allocate needs the link memory read of the head.
// A free writes the link memory in the execute cycle; an allocate uses the read data.
// Reset: synchronous; list chained in ascending order, head 0, count 0, no response.
`default_nettype none

module pool_free_list_allocator
   import pfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [SIZE_W-1:0]     req_request_size,
   input  wire logic [SIZE_W-1:0]     req_request_alignment,
   input  wire logic [SLOT_W-1:0]     req_slot,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [STATUS_W-1:0]   rsp_status,
   output logic      [SLOT_W-1:0]     rsp_granted_slot,
   output logic      [COUNT_W-1:0]    rsp_allocated_count,
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg;
   fsm_state_type      state_ff, state_in;

   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                act_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [SIZE_W-1:0]   align_ff;
   logic [SLOT_W-1:0]   slot_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                req_accept;
   logic                rsp_free;
   logic                mem_wr_en;
   logic [SLOT_W-1:0]   rd_link;

   pfa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pfa_link_mem u_link_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (head_ff[LINK_AW-1:0]),
      .rd_link (rd_link),
      .wr_en   (mem_wr_en),
      .wr_addr (slot_ff[LINK_AW-1:0]),
      .wr_link (head_ff)
   );

   assign req_stall  = (state_ff != FSM_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   // Capture the request; the head link read starts in the same cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff   <= req_action;
         size_ff  <= req_request_size;
         align_ff <= req_request_alignment;
         slot_ff  <= req_slot;
      end
   end

   // Next state, list update and response
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      mem_wr_en      = 1'b0;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_count_in   = rsp_count_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            // hold until the response register can take the result
            if (rsp_free) begin
               state_in       = FSM_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_granted_in = '0;
               if (act_ff == ACT_ALLOC) begin
                  if (size_ff > cfg.element_size) begin
                     rsp_status_in = ST_SIZE;
                  end else if (align_ff > cfg.max_alignment) begin
                     rsp_status_in = ST_ALIGN;
                  end else if (count_ff >= cfg.slot_limit) begin
                     rsp_status_in = ST_EXHAUSTED;
                  end else begin
                     // pop the head
                     rsp_granted_in = head_ff;
                     if ({1'b0, head_ff} < COUNT_W'(LINK_DEPTH)) begin
                        head_in = rd_link;
                     end else begin
                        head_in = '0;
                     end
                     count_in = count_ff + COUNT_W'(1);
                  end
               end else begin
                  if ({1'b0, slot_ff} >= cfg.slot_limit) begin
                     rsp_status_in = ST_RANGE;
                  end else if (count_ff == '0) begin
                     rsp_status_in = ST_NONE;
                  end else begin
                     // push the slot onto the head
                     mem_wr_en = 1'b1;
                     head_in   = slot_ff;
                     count_in  = count_ff - COUNT_W'(1);
                  end
               end
               rsp_count_in = count_in;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_slot    = rsp_granted_ff;
   assign rsp_allocated_count = rsp_count_ff;

endmodule

`default_nettype wire
